FILE: src/c2p_pkg.sv
package c2p_pkg;

  // Field widths.
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int MAG_WIDTH  = COORD_BITS + FRAC_BITS;
  localparam int ANG_LIMIT  = 360 << FRAC_BITS;
  localparam int ANG_WIDTH  = $clog2(ANG_LIMIT);

  // Square root: the radicand is (x*x + y*y) scaled by 2^(2*FRAC_BITS).
  localparam int RAD_W  = 2 * (COORD_BITS + FRAC_BITS);
  localparam int ROOT_W = MAG_WIDTH;
  localparam int REM_W  = ROOT_W + 1;

  // CORDIC datapath: coordinates are placed at bit 44 - COORD_BITS, with
  // headroom for the CORDIC gain and the sign.
  localparam int CORD_PRE = 44;
  localparam int CORD_SH  = CORD_PRE - COORD_BITS;
  localparam int CORD_W   = CORD_PRE + 3;

  // Angle accumulator in degrees with ZFRAC fraction bits.
  localparam int ZFRAC        = 20;
  localparam int ZW           = 31;
  localparam int ZU_W         = ZW - 1;
  localparam int CORDIC_STEPS = 27;
  localparam int ANG_DROP     = ZFRAC - FRAC_BITS;

  localparam logic signed [ZW-1:0] Z_HALF = ZW'(180 << ZFRAC);
  localparam logic signed [ZW-1:0] Z_FULL = ZW'(360 << ZFRAC);

  // atan(2^-i) in degrees, scaled by 2^ZFRAC.
  localparam logic signed [ZW-1:0] ATAN_DEG_TAB [CORDIC_STEPS] = '{
    ZW'(47185920), ZW'(27855475), ZW'(14718068), ZW'(7471121), ZW'(3750058),
    ZW'(1876857),  ZW'(938658),   ZW'(469357),   ZW'(234682),  ZW'(117342),
    ZW'(58671),    ZW'(29335),    ZW'(14668),    ZW'(7334),    ZW'(3667),
    ZW'(1833),     ZW'(917),      ZW'(458),      ZW'(229),     ZW'(115),
    ZW'(57),       ZW'(29),       ZW'(14),       ZW'(7),       ZW'(4),
    ZW'(2),        ZW'(1)
  };

  // Pipeline lengths; the shorter path is padded to the longer one.
  localparam int MAG_LAT  = 3 + ROOT_W;
  localparam int ANG_LAT  = CORDIC_STEPS + 3;
  localparam int PIPE_LAT = (MAG_LAT > ANG_LAT) ? MAG_LAT : ANG_LAT;
  localparam int MAG_PAD  = PIPE_LAT - MAG_LAT;
  localparam int ANG_PAD  = PIPE_LAT - ANG_LAT;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [MAG_WIDTH-1:0]         mag_t;
  typedef logic [ANG_WIDTH-1:0]         ang_t;

  typedef struct packed {
    mag_t magnitude;
    ang_t angle_deg;
  } c2p_res_t;

endpackage

FILE: src/c2p_if.sv
interface c2p_in_if import c2p_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t x_coord;
  coord_t y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

interface c2p_out_if import c2p_pkg::*; ();
  logic valid;
  logic ready;
  mag_t magnitude;
  ang_t angle_deg;

  modport source (output valid, output magnitude, output angle_deg, input ready);
  modport sink (input valid, input magnitude, input angle_deg, output ready);
endinterface

FILE: src/c2p_mag_pipe.sv
module c2p_mag_pipe import c2p_pkg::*; (
  input  logic   clk,
  input  logic   stage_en,
  input  coord_t x_coord,
  input  coord_t y_coord,
  output mag_t   magnitude
);

  logic [COORD_BITS-1:0]   ax_r, ay_r;
  logic [2*COORD_BITS-1:0] sqx_r, sqy_r;
  logic [RAD_W-1:0]        rad_r  [ROOT_W];
  logic [REM_W-1:0]        rem_r  [ROOT_W];
  logic [ROOT_W-1:0]       root_r [ROOT_W];

  // Front stages: absolute values, squares, scaled sum.
  always_ff @(posedge clk) begin
    if (stage_en) begin
      ax_r     <= x_coord[COORD_BITS-1] ? COORD_BITS'(-x_coord) : x_coord;
      ay_r     <= y_coord[COORD_BITS-1] ? COORD_BITS'(-y_coord) : y_coord;
      sqx_r    <= {{COORD_BITS{1'b0}}, ax_r} * {{COORD_BITS{1'b0}}, ax_r};
      sqy_r    <= {{COORD_BITS{1'b0}}, ay_r} * {{COORD_BITS{1'b0}}, ay_r};
      rad_r[0] <= {sqx_r + sqy_r, {(2 * FRAC_BITS){1'b0}}};
    end
  end

  // One result bit per stage, most significant first (restoring method).
  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    logic [REM_W-1:0]  rem_prev;
    logic [ROOT_W-1:0] root_prev;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_next
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
    end

    always_comb begin
      rem_sh = {rem_prev, rad_r[k][RAD_W-1 -: 2]};
      trial  = {1'b0, root_prev, 2'b01};
      diff   = rem_sh - trial;
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (stage_en) begin
        rem_r[k]  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_r[k] <= {root_prev[ROOT_W-2:0], ge};
      end
    end

    if (k < ROOT_W - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (stage_en) begin
          rad_r[k+1] <= {rad_r[k][RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  if (MAG_PAD > 0) begin : g_pad
    mag_t pad_r [MAG_PAD];
    always_ff @(posedge clk) begin
      if (stage_en) begin
        pad_r[0] <= root_r[ROOT_W-1];
        for (int p = 1; p < MAG_PAD; p++) begin
          pad_r[p] <= pad_r[p-1];
        end
      end
    end
    assign magnitude = pad_r[MAG_PAD-1];
  end else begin : g_nopad
    assign magnitude = root_r[ROOT_W-1];
  end

endmodule

FILE: src/c2p_cordic_pipe.sv
module c2p_cordic_pipe import c2p_pkg::*; (
  input  logic   clk,
  input  logic   stage_en,
  input  coord_t x_coord,
  input  coord_t y_coord,
  output ang_t   angle_deg
);

  logic signed [CORD_W-1:0] cx_r [CORDIC_STEPS];
  logic signed [CORD_W-1:0] cy_r [CORDIC_STEPS];
  logic signed [ZW-1:0]     z_r  [CORDIC_STEPS+1];
  logic                     zf_r [CORDIC_STEPS+1];
  logic [ZU_W-1:0]          zu_r;
  logic                     zfw_r;
  ang_t                     ang_r;

  logic signed [COORD_BITS:0] xe, ye, xs, ys;
  logic [ZU_W:0]              rnd_sum;
  logic [ZU_W-ANG_DROP:0]     rnd_val;

  // Points in the left half plane are turned by 180 degrees first.
  always_comb begin
    xe = {x_coord[COORD_BITS-1], x_coord};
    ye = {y_coord[COORD_BITS-1], y_coord};
    xs = xe[COORD_BITS] ? -xe : xe;
    ys = xe[COORD_BITS] ? -ye : ye;
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      cx_r[0] <= {{(CORD_W - COORD_BITS - 1 - CORD_SH){xs[COORD_BITS]}}, xs,
                  {CORD_SH{1'b0}}};
      cy_r[0] <= {{(CORD_W - COORD_BITS - 1 - CORD_SH){ys[COORD_BITS]}}, ys,
                  {CORD_SH{1'b0}}};
      z_r[0]  <= xe[COORD_BITS] ? Z_HALF : '0;
      zf_r[0] <= (x_coord == '0) && (y_coord == '0);
    end
  end

  // Vectoring micro-rotations, one per stage, driving y toward zero.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic pos;

    assign pos = !cy_r[i][CORD_W-1] && (cy_r[i] != '0);

    always_ff @(posedge clk) begin
      if (stage_en) begin
        z_r[i+1]  <= pos ? z_r[i] + ATAN_DEG_TAB[i] : z_r[i] - ATAN_DEG_TAB[i];
        zf_r[i+1] <= zf_r[i];
      end
    end

    if (i < CORDIC_STEPS - 1) begin : g_xy
      logic signed [CORD_W-1:0] dx, dy;

      assign dx = cy_r[i] >>> i;
      assign dy = cx_r[i] >>> i;

      always_ff @(posedge clk) begin
        if (stage_en) begin
          cx_r[i+1] <= pos ? cx_r[i] + dx : cx_r[i] - dx;
          cy_r[i+1] <= pos ? cy_r[i] - dy : cy_r[i] + dy;
        end
      end
    end
  end

  // Rounding to the output resolution; an angle that rounds up to a full
  // turn folds back to zero, and the origin always reads zero.
  always_comb begin
    rnd_sum = {1'b0, zu_r} + (ZU_W + 1)'(1 << (ANG_DROP - 1));
    rnd_val = rnd_sum[ZU_W:ANG_DROP];
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      if (z_r[CORDIC_STEPS][ZW-1]) begin
        zu_r <= ZU_W'(z_r[CORDIC_STEPS] + Z_FULL);
      end else if (z_r[CORDIC_STEPS] >= Z_FULL) begin
        zu_r <= ZU_W'(z_r[CORDIC_STEPS] - Z_FULL);
      end else begin
        zu_r <= ZU_W'(z_r[CORDIC_STEPS]);
      end
      zfw_r <= zf_r[CORDIC_STEPS];
      if (zfw_r || (rnd_val >= (ZU_W + 1 - ANG_DROP)'(ANG_LIMIT))) begin
        ang_r <= '0;
      end else begin
        ang_r <= rnd_val[ANG_WIDTH-1:0];
      end
    end
  end

  if (ANG_PAD > 0) begin : g_pad
    ang_t pad_r [ANG_PAD];
    always_ff @(posedge clk) begin
      if (stage_en) begin
        pad_r[0] <= ang_r;
        for (int p = 1; p < ANG_PAD; p++) begin
          pad_r[p] <= pad_r[p-1];
        end
      end
    end
    assign angle_deg = pad_r[ANG_PAD-1];
  end else begin : g_nopad
    assign angle_deg = ang_r;
  end

endmodule

FILE: src/c2p_out_buf.sv
module c2p_out_buf import c2p_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  c2p_res_t         push_data,
  output logic             full,
  c2p_out_if.source        out_chan
);

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  c2p_res_t head_r, skid_r;
  logic     take;

  assign take = out_valid_r && out_chan.ready;

  // The pipeline only pushes while the skid entry is empty, so at most
  // one item ever lands in it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (take) begin
      if (skid_valid_r) begin
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
      end
    end else if (!out_valid_r) begin
      out_valid_nxt = push;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid_r) begin
      head_r <= skid_r;
    end else if (take || !out_valid_r) begin
      head_r <= push_data;
    end
    if (out_valid_r && !take && push) begin
      skid_r <= push_data;
    end
  end

  assign full               = skid_valid_r;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.magnitude = head_r.magnitude;
  assign out_chan.angle_deg = head_r.angle_deg;

endmodule

FILE: src/cartesian_to_polar_top.sv
// Channel    Role    Payload
// in_chan    sink    x_coord (16 b signed), y_coord (16 b signed)
// out_chan   source  magnitude (24 b, 8 frac), angle_deg (17 b, 8 frac)
//
// One point is taken per clock while the output buffer is not full. A result
// passes through 30 pipeline stages, set by the 27-step CORDIC, then the output
// register. The magnitude path is a 24-stage square root that is padded.
// Reset clears the stage valid bits and the output buffer. A stall at the
// output freezes the pipeline once the two-entry output buffer is full.
module cartesian_to_polar_top import c2p_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  c2p_in_if.sink     in_chan,
  c2p_out_if.source  out_chan
);

  logic     stage_en;
  logic     buf_full;
  logic     vld_r [PIPE_LAT];
  c2p_res_t res;

  assign stage_en      = !buf_full;
  assign in_chan.ready = stage_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < PIPE_LAT; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else if (stage_en) begin
      vld_r[0] <= in_chan.valid;
      for (int s = 1; s < PIPE_LAT; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  c2p_mag_pipe u_mag (
    .clk       (clk),
    .stage_en  (stage_en),
    .x_coord   (in_chan.x_coord),
    .y_coord   (in_chan.y_coord),
    .magnitude (res.magnitude)
  );

  c2p_cordic_pipe u_cordic (
    .clk       (clk),
    .stage_en  (stage_en),
    .x_coord   (in_chan.x_coord),
    .y_coord   (in_chan.y_coord),
    .angle_deg (res.angle_deg)
  );

  c2p_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (stage_en && vld_r[PIPE_LAT-1]),
    .push_data (res),
    .full      (buf_full),
    .out_chan  (out_chan)
  );

endmodule

FILE: tb/cartesian_to_polar_top_test.sv
`timescale 1ns / 100ps

module cartesian_to_polar_top_test;
  import c2p_pkg::*;

  typedef struct {
    int x;
    int y;
    bit typed_in;
    int mag;
    int ang;
  } point_row_t;

  localparam int DIR_ROWS   = 22;
  localparam int RAND_ITEMS = 1400;
  localparam int ANG_TOL    = 1;
  localparam int Z_FRAC     = 20;
  localparam int ROT_STEPS  = 27;
  localparam int PRE_SHIFT  = 44 - COORD_BITS;
  localparam int DRAIN_CYC  = 40;

  // atan(2^-i) in degrees with Z_FRAC fraction bits.
  localparam longint ATAN_STEP [ROT_STEPS] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
    469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833, 917,
    458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  // Rows with typed_in set carry their result; the rest use polar_of.
  point_row_t dir_rows [DIR_ROWS] = '{
    '{0, 0, 1'b1, 0, 0},
    '{-5, 0, 1'b1, 1280, 46080},
    '{-32768, 0, 1'b1, 8388608, 46080},
    '{-1, 0, 1'b1, 256, 46080},
    '{32767, 0, 1'b1, 8388352, 0},
    '{1, 0, 1'b1, 256, 0},
    '{0, 1, 1'b1, 256, 23040},
    '{0, -1, 1'b1, 256, 69120},
    '{0, 32767, 1'b1, 8388352, 23040},
    '{0, -32768, 1'b1, 8388608, 69120},
    '{3, 4, 1'b0, 0, 0},
    '{-32768, -32768, 1'b0, 0, 0},
    '{32767, 32767, 1'b0, 0, 0},
    '{-32768, 32767, 1'b0, 0, 0},
    '{32767, -32768, 1'b0, 0, 0},
    '{32767, -1, 1'b0, 0, 0},
    '{1, -1, 1'b0, 0, 0},
    '{-1, 1, 1'b0, 0, 0},
    '{-1, -1, 1'b0, 0, 0},
    '{12345, -23456, 1'b0, 0, 0},
    '{-32768, 1, 1'b0, 0, 0},
    '{-32768, -1, 1'b0, 0, 0}
  };

  logic     clk;
  logic     rst_n;
  bit       calm;
  int       err_count;
  c2p_res_t polar_due[$];

  c2p_in_if  in_chan ();
  c2p_out_if out_chan ();

  cartesian_to_polar_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic c2p_res_t polar_of(coord_t px, coord_t py);
    longint          x, y, z, cx, cy, dx, dy, full, r;
    longint unsigned rad, root, probe;
    c2p_res_t        res;
    x = px;
    y = py;
    rad = longint'(x * x + y * y);
    rad = rad << (2 * FRAC_BITS);
    root = 0;
    probe = longint'(1) << 62;
    while (probe > rad) probe = probe >> 2;
    while (probe != 0) begin
      if (rad >= root + probe) begin
        rad = rad - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    res.magnitude = mag_t'(root);
    if (x == 0 && y == 0) begin
      res.angle_deg = '0;
      return res;
    end
    full = longint'(360) << Z_FRAC;
    z = 0;
    // The left half plane is turned by 180 degrees before the rotations.
    if (x < 0) begin
      x = -x;
      y = -y;
      z = longint'(180) << Z_FRAC;
    end
    cx = x <<< PRE_SHIFT;
    cy = y <<< PRE_SHIFT;
    for (int i = 0; i < ROT_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy > 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z = z + ATAN_STEP[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z = z - ATAN_STEP[i];
      end
    end
    if (z < 0) z = z + full;
    if (z >= full) z = z - full;
    r = (z + (longint'(1) << (Z_FRAC - FRAC_BITS - 1))) >>> (Z_FRAC - FRAC_BITS);
    if (r >= ANG_LIMIT) r = 0;
    res.angle_deg = ang_t'(r);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void pick_point(output coord_t x, output coord_t y);
    int ext [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
    case ($urandom_range(0, 9))
      4: begin
        x = coord_t'($urandom_range(0, 32) - 16);
        y = coord_t'($urandom_range(0, 32) - 16);
      end
      5: begin
        x = coord_t'($urandom);
        y = '0;
        if ($urandom_range(0, 1)) begin
          y = x;
          x = '0;
        end
      end
      6: begin
        x = coord_t'(ext[$urandom_range(0, 6)]);
        y = coord_t'(ext[$urandom_range(0, 6)]);
      end
      7: begin
        // Just below the positive x axis, where the angle nears a full turn.
        x = coord_t'($urandom_range(1000, 32767));
        y = coord_t'(-$urandom_range(1, 4));
      end
      8: begin
        x = coord_t'($urandom);
        y = coord_t'(x + $urandom_range(0, 4) - 2);
        if ($urandom_range(0, 1)) y = -y;
      end
      9: begin
        x = coord_t'(-$urandom_range(1, 32768));
        y = coord_t'($urandom_range(0, 6) - 3);
      end
      default: begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t ns: %s", $realtime, what);
    err_count++;
  endtask

  task automatic send_point(coord_t x, coord_t y, c2p_res_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.x_coord <= x;
    in_chan.y_coord <= y;
    do @(posedge clk); while (!in_chan.ready);
    polar_due.push_back(want);
  endtask

  initial begin
    point_row_t row;
    coord_t     x;
    coord_t     y;
    c2p_res_t   want;
    err_count = 0;
    calm = 1'b0;
    in_chan.valid   <= 1'b0;
    in_chan.x_coord <= '0;
    in_chan.y_coord <= '0;
    rst_n <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.typed_in) begin
        want.magnitude = mag_t'(row.mag);
        want.angle_deg = ang_t'(row.ang);
      end else begin
        want = polar_of(coord_t'(row.x), coord_t'(row.y));
      end
      send_point(coord_t'(row.x), coord_t'(row.y), want);
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      pick_point(x, y);
      send_point(x, y, polar_of(x, y));
    end
    in_chan.valid <= 1'b0;
    while (polar_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int stall;
    int run;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    c2p_res_t want;
    int       d;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (polar_due.size() == 0) begin
        report_mismatch($sformatf("unexpected item: magnitude %0d angle %0d",
                                  out_chan.magnitude, out_chan.angle_deg));
      end else begin
        want = polar_due.pop_front();
        if ($isunknown(out_chan.magnitude) || out_chan.magnitude !== want.magnitude)
          report_mismatch($sformatf("magnitude %0d, expected %0d",
                                    out_chan.magnitude, want.magnitude));
        // The angle may be off by one step, also across the wrap at 360 degrees.
        d = int'(out_chan.angle_deg) - int'(want.angle_deg);
        if (d < 0) d = d + ANG_LIMIT;
        if ($isunknown(out_chan.angle_deg) || (d > ANG_TOL && d < ANG_LIMIT - ANG_TOL))
          report_mismatch($sformatf("angle %0d, expected %0d",
                                    out_chan.angle_deg, want.angle_deg));
      end
    end
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
src/c2p_pkg.sv
src/c2p_if.sv
src/c2p_mag_pipe.sv
src/c2p_cordic_pipe.sv
src/c2p_out_buf.sv
src/cartesian_to_polar_top.sv
tb/cartesian_to_polar_top_test.sv
